@@ rtl/dls_pkg.sv @@
// ----------------------------------------------------------------------------
// dls_pkg: shared constants for the log2-by-squaring core
// Sequencer state codes, IEEE double field constants and the sqrt(0.5) bound.
// ----------------------------------------------------------------------------
package dls_pkg;

    localparam int FRAC_W = 52;
    localparam int EXP_W  = 11;
    localparam int MANT_W = FRAC_W + 1;
    localparam int PROD_W = 2 * MANT_W;
    localparam int HI_W   = 27;
    localparam int LO_W   = MANT_W - HI_W;
    localparam int CNT_W  = 6;

    localparam logic [63:0]       HALF_BITS      = 64'h3fe0_0000_0000_0000;
    localparam logic [63:0]       MINUS_ONE_BITS = 64'hbff0_0000_0000_0000;
    localparam logic [63:0]       HIDDEN_BIT     = 64'h0010_0000_0000_0000;
    localparam logic [63:0]       POS_INF_BITS   = 64'h7ff0_0000_0000_0000;
    localparam logic [MANT_W-1:0] SQRT_HALF_MANT = 53'h16a09e667f3bcc;
    localparam logic [EXP_W-1:0]  BIAS_LESS_ONE  = 11'h3fe;
    localparam logic [EXP_W-1:0]  EXP_MAX        = 11'h7ff;
    localparam logic [CNT_W-1:0]  LEAD_LIMIT     = 6'd53;
    localparam logic [CNT_W-1:0]  TOP_BIT_IDX    = 6'd52;

    typedef logic [2:0] t_state;
    localparam t_state ST_IDLE = 3'd0;
    localparam t_state ST_DEC  = 3'd1;
    localparam t_state ST_MUL  = 3'd2;
    localparam t_state ST_NORM = 3'd3;
    localparam t_state ST_FIN  = 3'd4;

endpackage

@@ rtl/dls_if.sv @@
// ----------------------------------------------------------------------------
// dls_x_if / dls_log_if: request channels of the log2-by-squaring core
// Valid/ready handshake carrying one IEEE double bit pattern.
// ----------------------------------------------------------------------------
interface dls_x_if;
    logic        valid;
    logic        ready;
    logic [63:0] x_bits;
    modport source (output valid, output x_bits, input ready);
    modport sink   (input valid, input x_bits, output ready);
endinterface

interface dls_log_if;
    logic        valid;
    logic        ready;
    logic [63:0] log_bits;
    modport source (output valid, output log_bits, input ready);
    modport sink   (input valid, input log_bits, output ready);
endinterface

@@ rtl/double_log2_by_squaring_core.sv @@
// ----------------------------------------------------------------------------
// double_log2_by_squaring_core: log2 of a double in [0.5,1) by squaring
// Exactly one half skips squaring and goes straight to the result; otherwise each
// squaring runs decide, 4 multiply phases on one shared 27x27 multiplier and
// round/normalise, with up to 106 squarings per request.
// Flow: one request in flight; the next is taken after its result loads.
// Reset (synchronous, active low) returns the sequencer to idle, no result.
// ----------------------------------------------------------------------------
module double_log2_by_squaring_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dls_x_if.sink    i_x,
    dls_log_if.source o_log
);

    dls_pkg::t_state r_state, n_state;
    logic [63:0]                  r_x, n_x;
    logic [dls_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [dls_pkg::CNT_W-1:0]    r_k, n_k;
    logic                         r_lead, n_lead;
    logic                         r_dbl, n_dbl;
    logic                         r_half, n_half;
    logic [dls_pkg::MANT_W-1:0]   r_bits, n_bits;
    logic [1:0]                   r_ph, n_ph;
    logic [53:0]                  r_prod, n_prod;
    logic [dls_pkg::PROD_W-1:0]   r_p, n_p;
    logic [63:0]                  r_out, n_out;
    logic                         r_ov, n_ov;

    logic [dls_pkg::MANT_W-1:0] mant;
    logic [dls_pkg::HI_W-1:0]   m_hi, mul_a, mul_b;
    logic [dls_pkg::LO_W-1:0]   m_lo;
    logic                       above;

    logic                       sh;
    logic [dls_pkg::EXP_W-1:0]  ex;
    logic signed [13:0]         er;
    logic signed [13:0]         dd;
    logic [6:0]                 dsh;
    logic [6:0]                 s_m1;
    logic [dls_pkg::PROD_W-1:0] t_v;
    logic                       sticky, guard, rnd;
    logic [dls_pkg::EXP_W-1:0]  ef;
    logic [63:0]                sq;
    logic [dls_pkg::MANT_W-1:0] sum53;

    assign mant  = {1'b1, r_x[dls_pkg::FRAC_W-1:0]};
    assign m_hi  = mant[dls_pkg::MANT_W-1:dls_pkg::LO_W];
    assign m_lo  = mant[dls_pkg::LO_W-1:0];
    assign above = mant > dls_pkg::SQRT_HALF_MANT;

    always_comb begin
        mul_a = (r_ph == 2'd2) ? {1'b0, m_lo} : m_hi;
        mul_b = (r_ph == 2'd0) ? m_hi : {1'b0, m_lo};
    end

    // round and normalise the square of r_x
    always_comb begin
        sh   = r_p[dls_pkg::PROD_W-1];
        ex   = r_x[62:52];
        er   = $signed({2'b00, ex, 1'b0}) - 14'sd1023 + $signed({13'd0, sh});
        dd   = 14'sd1 - er;
        if (er > 14'sd0) begin
            dsh = 7'd0;
        end else if (dd > 14'sd55) begin
            dsh = 7'd55;
        end else begin
            dsh = dd[6:0];
        end
        s_m1   = 7'd51 + {6'd0, sh} + dsh;
        t_v    = r_p >> s_m1;
        sticky = (t_v << s_m1) != r_p;
        guard  = t_v[0];
        rnd    = guard & (sticky | t_v[1]);
        ef     = (er > 14'sd0) ? er[10:0] : '0;
        if (ex == '0) begin
            sq = '0;
        end else if (ex == dls_pkg::EXP_MAX) begin
            if (r_x[51:0] == '0) begin
                sq = dls_pkg::POS_INF_BITS;
            end else begin
                sq = {r_x[63], dls_pkg::EXP_MAX, 1'b1, r_x[50:0]};
            end
        end else if (er >= 14'sd2047) begin
            sq = dls_pkg::POS_INF_BITS;
        end else begin
            sq = {1'b0, ef, t_v[52:1]} + {63'd0, rnd};
        end
    end

    assign sum53 = {1'b0, r_bits[dls_pkg::MANT_W-1:1]} + {52'd0, r_bits[0]};

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_lead  = r_lead;
        n_dbl   = r_dbl;
        n_half  = r_half;
        n_bits  = r_bits;
        n_ph    = r_ph;
        n_prod  = r_prod;
        n_p     = r_p;
        n_out   = r_out;
        n_ov    = r_ov;
        if (o_log.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            dls_pkg::ST_IDLE: begin
                if (i_x.valid) begin
                    n_x    = i_x.x_bits;
                    n_cnt  = '0;
                    n_k    = '0;
                    n_lead = 1'b1;
                    n_bits = '0;
                    n_half = i_x.x_bits == dls_pkg::HALF_BITS;
                    n_state = (i_x.x_bits == dls_pkg::HALF_BITS) ? dls_pkg::ST_FIN
                                                                 : dls_pkg::ST_DEC;
                end
            end
            dls_pkg::ST_DEC: begin
                n_ph = '0;
                if (r_lead) begin
                    if (r_cnt == dls_pkg::LEAD_LIMIT) begin
                        n_state = dls_pkg::ST_FIN;
                    end else begin
                        n_dbl   = !above;
                        if (above) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                        n_state = dls_pkg::ST_MUL;
                    end
                end else begin
                    n_dbl = !above;
                    if (!above) begin
                        n_bits[r_k] = 1'b1;
                    end
                    n_state = dls_pkg::ST_MUL;
                end
            end
            dls_pkg::ST_MUL: begin
                n_prod = mul_a * mul_b;
                n_ph   = r_ph + 1'b1;
                case (r_ph)
                    2'd0: n_p = '0;
                    2'd1: n_p = r_p + ({52'd0, r_prod} << 52);
                    2'd2: n_p = r_p + ({52'd0, r_prod} << 27);
                    default: begin
                        n_p     = r_p + {52'd0, r_prod};
                        n_state = dls_pkg::ST_NORM;
                    end
                endcase
            end
            dls_pkg::ST_NORM: begin
                n_x     = sq + (r_dbl ? dls_pkg::HIDDEN_BIT : 64'd0);
                n_state = dls_pkg::ST_DEC;
                if (r_lead) begin
                    if (r_dbl) begin
                        n_lead = 1'b0;
                        n_k    = dls_pkg::TOP_BIT_IDX;
                    end
                end else if (r_k == '0) begin
                    n_state = dls_pkg::ST_FIN;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            dls_pkg::ST_FIN: begin
                if (!r_ov || o_log.ready) begin
                    n_ov    = 1'b1;
                    n_out   = r_half ? dls_pkg::MINUS_ONE_BITS
                                     : ({1'b1, dls_pkg::BIAS_LESS_ONE - {5'd0, r_cnt}, 52'd0}
                                        | {11'd0, sum53});
                    n_state = dls_pkg::ST_IDLE;
                end
            end
            default: n_state = dls_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dls_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_x    <= n_x;
        r_cnt  <= n_cnt;
        r_k    <= n_k;
        r_lead <= n_lead;
        r_dbl  <= n_dbl;
        r_half <= n_half;
        r_bits <= n_bits;
        r_ph   <= n_ph;
        r_prod <= n_prod;
        r_p    <= n_p;
        r_out  <= n_out;
    end

    assign i_x.ready      = r_state == dls_pkg::ST_IDLE;
    assign o_log.valid    = r_ov;
    assign o_log.log_bits = r_out;

endmodule

@@ rtl/dls_chk.sv @@
// ----------------------------------------------------------------------------
// dls_chk: port-level checks for the log2-by-squaring core
// Watches the request channels and reset behaviour over time.
// ----------------------------------------------------------------------------
module dls_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_bits
);

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("core ready straight after taking a request");

    a_no_result_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_bits))
        else $error("stalled result dropped or changed");

endmodule

bind double_log2_by_squaring_core dls_chk u_dls_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_x.valid),
    .i_in_ready  (i_x.ready),
    .i_out_valid (o_log.valid),
    .i_out_ready (o_log.ready),
    .i_out_bits  (o_log.log_bits)
);

@@ verif/double_log2_by_squaring_core_test.sv @@
// ----------------------------------------------------------------------------
// double_log2_by_squaring_core_test: self-checking bench for the log2 core
// Drives IEEE double patterns through the request channel, predicts each
// log2 bit pattern with host double squaring and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module double_log2_by_squaring_core_test;

    localparam int  CYCLE_LIMIT = 4_000_000;
    localparam int  DRAIN_CYCLES = 700;
    localparam int  RANDOM_ITEMS = 1180;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dls_x_if   x_ch ();
    dls_log_if log_ch ();

    double_log2_by_squaring_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_x     (x_ch),
        .o_log   (log_ch)
    );

    logic [63:0] expected_logs[$];
    int          idle_pct = 24;
    int          errors = 0;
    int          sent = 0;
    int          checked = 0;
    int          cycles = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        x_ch.valid  = 1'b0;
        x_ch.x_bits = '0;
        log_ch.ready = 1'b0;
    end

    function automatic logic [63:0] square_double(input logic [63:0] b);
        real d;
        d = $bitstoreal(b);
        return $realtobits(d * d);
    endfunction

    function automatic bit mant_above_bound(input logic [63:0] b);
        logic [dls_pkg::MANT_W-1:0] m;
        m = {1'b1, b[dls_pkg::FRAC_W-1:0]};
        return m > dls_pkg::SQRT_HALF_MANT;
    endfunction

    function automatic logic [63:0] predict_log2(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] frac_acc;
        int          lead;
        bit          broke;
        x = x_in;
        frac_acc = '0;
        lead = 0;
        broke = 0;
        if (x == dls_pkg::HALF_BITS)
            return dls_pkg::MINUS_ONE_BITS;
        while (lead <= dls_pkg::FRAC_W && !broke) begin
            if (mant_above_bound(x)) begin
                lead++;
                x = square_double(x);
            end else begin
                x = square_double(x) + dls_pkg::HIDDEN_BIT;
                broke = 1;
            end
        end
        if (broke) begin
            for (int k = 62; k >= 10; k--) begin
                if (mant_above_bound(x)) begin
                    x = square_double(x);
                end else begin
                    frac_acc[k] = 1'b1;
                    x = square_double(x) + dls_pkg::HIDDEN_BIT;
                end
            end
        end
        if (frac_acc[10])
            frac_acc = frac_acc + 64'h800;
        frac_acc = frac_acc >> 11;
        frac_acc[63] = 1'b1;
        frac_acc = frac_acc
                   | (64'(dls_pkg::BIAS_LESS_ONE - 11'(lead)) << dls_pkg::FRAC_W);
        return frac_acc;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        log_ch.ready = i_rst_n && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && log_ch.valid && log_ch.ready) begin
            if (expected_logs.size() == 0) begin
                $display("%0t: unexpected result %h", $time, log_ch.log_bits);
                errors++;
            end else begin
                logic [63:0] want;
                want = expected_logs.pop_front();
                checked++;
                if (log_ch.log_bits !== want) begin
                    $display("%0t: log_bits expected %h actual %h",
                             $time, want, log_ch.log_bits);
                    errors++;
                end
            end
        end
    end

    task automatic send_x(input logic [63:0] v);
        while ($urandom_range(99) < idle_pct)
            @(negedge i_clk);
        x_ch.valid  = 1'b1;
        x_ch.x_bits = v;
        do @(posedge i_clk); while (!x_ch.ready);
        expected_logs.push_back(predict_log2(v));
        sent++;
        @(negedge i_clk);
        x_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_logs.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_directed();
        logic [63:0] cases[$];
        cases = '{64'h3fe0_0000_0000_0000, 64'h3fe0_0000_0000_0001,
                  64'h3fef_ffff_ffff_ffff, 64'h3fe6_a09e_667f_3bcc,
                  64'h3fe6_a09e_667f_3bcb, 64'h3fe6_a09e_667f_3bcd,
                  64'h3fe8_0000_0000_0000, 64'h3fea_aaaa_aaaa_aaaa,
                  64'h3fe5_5555_5555_5555, 64'h3ff0_0000_0000_0000,
                  64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                  64'h0000_0000_0000_0001, 64'h000f_ffff_ffff_ffff,
                  64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000,
                  64'h7ff8_0000_0000_0000, 64'h7fef_ffff_ffff_ffff,
                  64'hbfe8_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
                  64'h3fef_ffff_ffff_fff0, 64'h3fe6_a09e_0000_0000};
        foreach (cases[n])
            send_x(cases[n]);
    endtask

    task automatic test_random(input int count);
        logic [63:0] v;
        int          kind;
        for (int n = 0; n < count; n++) begin
            if (n == count / 3)
                idle_pct = 0;
            if (n == count / 2)
                idle_pct = 24;
            kind = $urandom_range(99);
            v = {$urandom, $urandom};
            if (kind < 70)
                v[63:52] = 12'h3fe;
            else if (kind < 85)
                v = {12'h3fe, dls_pkg::SQRT_HALF_MANT[51:0]
                              + 52'($signed($urandom_range(64)) - 32)};
            else if (kind < 90)
                v = {12'h3fe, 52'hf_ffff_ffff_ffff - 52'($urandom_range(4096))};
            send_x(v);
        end
    endtask

    task automatic test_pause_until_drained();
        send_x({12'h3fe, 20'($urandom), $urandom});
        wait_drained();
        send_x(dls_pkg::HALF_BITS);
        send_x({12'h3fe, 20'($urandom), $urandom});
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_pause_until_drained();
        test_random(RANDOM_ITEMS);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Sent %0d arguments (directed edge values, near-bound and random", sent);
        $display("patterns) and checked %0d log2 results.", checked);
        if (errors == 0 && expected_logs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
